@@ sv/lhp_pkg.sv @@
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, codes and constants of the latency histogram engine.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int FINE_BIN_COUNT_DEF = 200;
    localparam int FINE_BIN_WIDTH_DEF = 10;

    localparam int KIND_W = 2;
    localparam int LAT_W  = 32;
    localparam int PM_W   = 10;
    localparam int SUM_W  = 48;
    localparam int TGT_W  = LAT_W + PM_W;

    localparam int EDGE_COUNT   = 8;
    localparam int COARSE_COUNT = EDGE_COUNT + 1;
    localparam int CIDX_W       = 4;

    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 4 * LAT_W + SUM_W;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [LAT_W-1:0] ALL32   = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [PM_W-1:0]  PM_DIV  = 10'd1000;

    localparam logic [LAT_W-1:0] EDGE_US [EDGE_COUNT] = '{
        32'd2000, 32'd5000, 32'd10000, 32'd25000,
        32'd50000, 32'd100000, 32'd250000, 32'd500000
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LAT_W-1:0]  latency_us;
        logic [PM_W-1:0]   permille;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } qwr_t;

    typedef struct packed {
        logic [LAT_W-1:0] percentile_us;
        logic [LAT_W-1:0] sample_total;
        logic [LAT_W-1:0] min_us;
        logic [LAT_W-1:0] max_us;
        logic [SUM_W-1:0] sum_us;
    } result_t;

    function automatic logic [CIDX_W-1:0] coarse_index(input logic [LAT_W-1:0] us);
        logic [CIDX_W-1:0] idx;
        idx = CIDX_W'(EDGE_COUNT);
        for (int k = EDGE_COUNT - 1; k >= 0; k--) begin
            if (us < EDGE_US[k]) begin
                idx = CIDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/lhp_ram.sv @@
// ----------------------------------------------------------------------------
// lhp_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 200,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lhp_front.sv @@
// ----------------------------------------------------------------------------
// lhp_front
// Input side: unpacks a word into a command and drops unknown kinds.
// ----------------------------------------------------------------------------
module lhp_front
    import lhp_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    input  logic                 q_full,
    output qwr_t                 q_wr
);

    logic known;

    always_comb begin
        unique case (s_tuser) inside
            KIND_ADD, KIND_QUERY, KIND_CLEAR: known = 1'b1;
            default:                          known = 1'b0;
        endcase
    end

    assign s_tready            = !q_full;
    assign q_wr.push           = s_tvalid && !q_full && known;
    assign q_wr.cmd.kind       = s_tuser;
    assign q_wr.cmd.latency_us = s_tdata[LAT_W-1:0];
    assign q_wr.cmd.permille   = s_tdata[LAT_W +: PM_W];

endmodule

@@ sv/lhp_queue.sv @@
// ----------------------------------------------------------------------------
// lhp_queue
// Short command queue between the input side and the engine.
// ----------------------------------------------------------------------------
module lhp_queue
    import lhp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  qwr_t q_wr,
    output logic q_full,
    input  logic q_pop,
    output logic q_empty,
    output cmd_t q_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign q_full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = q_wr.push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_cmd   = entry_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wp_reg] <= q_wr.cmd;
        end
    end

endmodule

@@ sv/lhp_engine.sv @@
// ----------------------------------------------------------------------------
// lhp_engine
// Back end: bin updates, clearing sweep, percentile walk and result register.
// ----------------------------------------------------------------------------
module lhp_engine
    import lhp_pkg::*;
#(
    parameter int FINE_BIN_COUNT = FINE_BIN_COUNT_DEF,
    parameter int FINE_BIN_WIDTH = FINE_BIN_WIDTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_empty,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int IDX_W  = (FINE_BIN_COUNT > 1) ? $clog2(FINE_BIN_COUNT) : 1;
    localparam int SPAN   = FINE_BIN_COUNT * FINE_BIN_WIDTH;
    localparam int SPAN_W = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int PROD_W = 2 * SPAN_W + 1;
    localparam int ACC_W  = LAT_W + $clog2(FINE_BIN_COUNT + COARSE_COUNT);
    localparam int CMP_W  = (ACC_W > TGT_W) ? ACC_W : TGT_W;
    localparam int DCNT_W = 2;
    localparam int KC_W   = $clog2(EDGE_COUNT);

    // target = floor((P >> 3) * ceil(2^46 / 125) / 2^46), exact for a 42-bit P,
    // built from four 20x20 partial products
    localparam int MUL_STEPS = 4;
    localparam int HALF_W    = 20;
    localparam int MACC_W    = 4 * HALF_W;
    localparam int RCP_SH    = 46;
    localparam logic [2*HALF_W-1:0] PM_RECIP = 40'd562949953422;

    localparam logic [SPAN_W:0]  RECIP   = (SPAN_W + 1)'((64'd1 << SPAN_W) / FINE_BIN_WIDTH);
    localparam logic [SPAN_W:0]  WIDTH_V = (SPAN_W + 1)'(FINE_BIN_WIDTH);
    localparam logic [LAT_W-1:0] SPAN_V  = LAT_W'(SPAN);
    localparam logic [LAT_W-1:0] WIDTH_L = LAT_W'(FINE_BIN_WIDTH);

    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ADD0  = 4'd2;
    localparam logic [3:0] ST_ADD1  = 4'd3;
    localparam logic [3:0] ST_ADD2  = 4'd4;
    localparam logic [3:0] ST_ADD3  = 4'd5;
    localparam logic [3:0] ST_ADD4  = 4'd6;
    localparam logic [3:0] ST_QMUL  = 4'd7;
    localparam logic [3:0] ST_QDIV  = 4'd8;
    localparam logic [3:0] ST_QFRD  = 4'd9;
    localparam logic [3:0] ST_QFCK  = 4'd10;
    localparam logic [3:0] ST_QC    = 4'd11;
    localparam logic [3:0] ST_EMIT  = 4'd12;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [IDX_W-1:0]  sweep_idx_reg;
    logic [IDX_W-1:0]  walk_idx_reg;
    logic [KC_W-1:0]   k_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              out_valid_reg;

    cmd_t              cmd_reg;
    logic [LAT_W-1:0]  count_reg;
    logic [LAT_W-1:0]  min_reg;
    logic [LAT_W-1:0]  max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LAT_W-1:0]  coarse_reg [COARSE_COUNT];

    logic [PROD_W-1:0] prod1_reg;
    logic [IDX_W-1:0]  q0_reg;
    logic [SPAN_W:0]   mw_reg;
    logic [IDX_W-1:0]  fidx_reg;
    logic [TGT_W-1:0]  dq_reg;
    logic [MACC_W-1:0] macc_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [LAT_W-1:0]  edge_reg;
    logic [LAT_W-1:0]  pct_reg;
    result_t           out_reg;

    logic [LAT_W-1:0]    us;
    logic                in_fine;
    logic [SPAN_W-1:0]   us_lo;
    logic [CIDX_W-1:0]   cidx;
    logic [CIDX_W-1:0]   caddr;
    logic [LAT_W-1:0]    cval;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    sum_sat;
    logic [SPAN_W:0]     resid;
    logic [IDX_W-1:0]    fidx_c;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [2*HALF_W-1:0] pp;
    logic [MACC_W-1:0]   pp_sh;
    logic [MACC_W-1:0]   macc_n;
    logic [ACC_W-1:0]    acc_f;
    logic [ACC_W-1:0]    acc_c;
    logic                hit_f;
    logic                hit_c;
    logic                emit_ok;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LAT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LAT_W-1:0]  ram_rdata;

    lhp_ram #(
        .WIDTH (LAT_W),
        .DEPTH (FINE_BIN_COUNT),
        .AW    (IDX_W)
    ) u_fine_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign us      = cmd_reg.latency_us;
    assign in_fine = (us < SPAN_V);
    assign us_lo   = us[SPAN_W-1:0];
    assign cidx    = coarse_index(us);
    assign caddr   = (state_reg == ST_QC) ? CIDX_W'(k_reg) : cidx;
    assign cval    = coarse_reg[caddr];

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(us);
    assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    // quotient estimate is low by at most one
    assign resid  = (SPAN_W + 1)'(us_lo) - mw_reg;
    assign fidx_c = q0_reg + IDX_W'(resid >= WIDTH_V);

    assign mul_a  = div_cnt_reg[1] ? HALF_W'(dq_reg[TGT_W-1:3+HALF_W]) : dq_reg[3 +: HALF_W];
    assign mul_b  = div_cnt_reg[0] ? PM_RECIP[HALF_W +: HALF_W] : PM_RECIP[HALF_W-1:0];
    assign pp     = (2 * HALF_W)'(mul_a) * (2 * HALF_W)'(mul_b);
    assign macc_n = macc_reg + pp_sh;

    always_comb begin
        case (div_cnt_reg)
            2'd0:    pp_sh = MACC_W'(pp);
            2'd3:    pp_sh = MACC_W'(pp) << (2 * HALF_W);
            default: pp_sh = MACC_W'(pp) << HALF_W;
        endcase
    end

    assign acc_f   = acc_reg + ACC_W'(ram_rdata);
    assign acc_c   = acc_reg + ACC_W'(cval);
    assign hit_f   = (CMP_W'(acc_f) >= CMP_W'(dq_reg));
    assign hit_c   = (CMP_W'(acc_c) >= CMP_W'(dq_reg));
    assign emit_ok = !out_valid_reg || res_ready;

    assign ram_we    = (state_reg == ST_SWEEP) || (state_reg == ST_ADD4);
    assign ram_waddr = (state_reg == ST_SWEEP) ? sweep_idx_reg : fidx_reg;
    assign ram_wdata = (state_reg == ST_SWEEP) ? '0 :
                       (ram_rdata == ALL32) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_raddr = (state_reg == ST_ADD3) ? fidx_c : walk_idx_reg;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sweep_idx_reg == IDX_W'(FINE_BIN_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_cmd.kind)
                        KIND_ADD:   state_next = ST_ADD0;
                        KIND_QUERY: state_next = ST_QMUL;
                        KIND_CLEAR: state_next = ST_SWEEP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD0: state_next = in_fine ? ST_ADD1 : ST_IDLE;
            ST_ADD1: state_next = ST_ADD2;
            ST_ADD2: state_next = ST_ADD3;
            ST_ADD3: state_next = ST_ADD4;
            ST_ADD4: state_next = ST_IDLE;
            ST_QMUL: state_next = ST_QDIV;
            ST_QDIV: begin
                if (div_cnt_reg == DCNT_W'(MUL_STEPS - 1)) begin
                    state_next = ST_QFRD;
                end
            end
            ST_QFRD: state_next = ST_QFCK;
            ST_QFCK: begin
                if (hit_f) begin
                    state_next = ST_EMIT;
                end else if (walk_idx_reg == IDX_W'(FINE_BIN_COUNT - 1)) begin
                    state_next = ST_QC;
                end else begin
                    state_next = ST_QFRD;
                end
            end
            ST_QC: begin
                if (hit_c || (k_reg == KC_W'(EDGE_COUNT - 1))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            min_reg       <= ALL32;
            max_reg       <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < COARSE_COUNT; i++) begin
                coarse_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP) begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            if (q_pop && (q_cmd.kind == KIND_CLEAR)) begin
                sweep_idx_reg <= '0;
                count_reg     <= '0;
                min_reg       <= ALL32;
                max_reg       <= '0;
                sum_reg       <= '0;
                for (int i = 0; i < COARSE_COUNT; i++) begin
                    coarse_reg[i] <= '0;
                end
            end
            if (state_reg == ST_ADD0) begin
                if (count_reg != ALL32) begin
                    count_reg <= count_reg + 1'b1;
                end
                sum_reg <= sum_sat;
                if (us < min_reg) begin
                    min_reg <= us;
                end
                if (us > max_reg) begin
                    max_reg <= us;
                end
                if (!in_fine && (cval != ALL32)) begin
                    coarse_reg[cidx] <= cval + 1'b1;
                end
            end
            if ((state_reg == ST_EMIT) && emit_ok) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        case (state_reg)
            ST_ADD0: prod1_reg <= PROD_W'(us_lo) * PROD_W'(RECIP);
            ST_ADD1: q0_reg    <= prod1_reg[SPAN_W +: IDX_W];
            ST_ADD2: mw_reg    <= (SPAN_W + 1)'(q0_reg) * WIDTH_V;
            ST_ADD3: fidx_reg  <= fidx_c;
            ST_QMUL: begin
                dq_reg       <= TGT_W'(count_reg) * TGT_W'(cmd_reg.permille);
                macc_reg     <= '0;
                div_cnt_reg  <= '0;
                acc_reg      <= '0;
                edge_reg     <= WIDTH_L;
                walk_idx_reg <= '0;
                k_reg        <= '0;
            end
            ST_QDIV: begin
                macc_reg    <= macc_n;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(MUL_STEPS - 1)) begin
                    dq_reg <= TGT_W'(macc_n[MACC_W-1:RCP_SH]);
                end
            end
            ST_QFCK: begin
                acc_reg <= acc_f;
                if (hit_f) begin
                    pct_reg <= edge_reg;
                end else begin
                    edge_reg     <= edge_reg + WIDTH_L;
                    walk_idx_reg <= walk_idx_reg + 1'b1;
                end
            end
            ST_QC: begin
                acc_reg <= acc_c;
                k_reg   <= k_reg + 1'b1;
                if (hit_c) begin
                    pct_reg <= EDGE_US[k_reg];
                end else begin
                    pct_reg <= max_reg;
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    out_reg.percentile_us <= pct_reg;
                    out_reg.sample_total  <= count_reg;
                    out_reg.min_us        <= min_reg;
                    out_reg.max_us        <= max_reg;
                    out_reg.sum_us        <= sum_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ sv/latency_histogram_percentile.sv @@
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Latency histogram with running count, min, max, sum and percentile query.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | latency_us[31:0], permille[41:32], pad        | kind[1:0]
//  m_      | out | percentile_us, sample_total, min_us, max_us,  | -
//          |     | sum_us[175:128]                               |
//
//  Add: statistics update (and the coarse bin for a coarse sample), then for a
//  fine sample a RAM read-modify-write behind a reciprocal multiply for the bin index.
//  Query: reciprocal multiply for the divide by 1000, a walk over the fine bins
//  (registered RAM read), then over the coarse bins, then any m_ stall.
//  Clear: resets the statistics and starts the sweep below.
//  Reset and every clear run a sweep over the bin RAM.
//  A 4-entry queue absorbs words while the engine works or m_ stalls; s_tready
//  drops while it is full.
// ----------------------------------------------------------------------------
module latency_histogram_percentile
    import lhp_pkg::*;
#(
    parameter int FINE_BIN_COUNT = FINE_BIN_COUNT_DEF,
    parameter int FINE_BIN_WIDTH = FINE_BIN_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // latency_us, permille
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // percentile_us, sample_total, min_us,
                                            // max_us, sum_us
);

    qwr_t    q_wr;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    cmd_t    q_cmd;
    result_t res;

    lhp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    lhp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_cmd   (q_cmd)
    );

    lhp_engine #(
        .FINE_BIN_COUNT (FINE_BIN_COUNT),
        .FINE_BIN_WIDTH (FINE_BIN_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.sum_us, res.max_us, res.min_us, res.sample_total,
                      res.percentile_us};

endmodule

@@ sv/lhp_checker.sv @@
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks of the latency histogram, bound to the top level.
// ----------------------------------------------------------------------------
module lhp_checker
    import lhp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [LAT_W-1:0] total;
    logic [LAT_W-1:0] min_us;
    logic [LAT_W-1:0] max_us;
    logic [SUM_W-1:0] sum_us;

    assign total  = m_tdata[LAT_W +: LAT_W];
    assign min_us = m_tdata[2*LAT_W +: LAT_W];
    assign max_us = m_tdata[3*LAT_W +: LAT_W];
    assign sum_us = m_tdata[4*LAT_W +: SUM_W];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (total == '0) |-> (min_us == ALL32) && (max_us == '0) && (sum_us == '0))
        else $error("empty statistics not at cleared values");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (total != '0) |-> (min_us <= max_us) && (sum_us >= SUM_W'(max_us)))
        else $error("min, max and sum inconsistent");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb_latency_histogram_percentile.sv @@
// ----------------------------------------------------------------------------
// tb_latency_histogram_percentile
// Self-checking bench for the latency histogram and percentile engine.
// Words are driven on the s_ stream and a scoreboard keeps its own copy of
// the bins and running statistics. Every query predicts a result that is
// compared field by field with the next m_ word. The run covers a directed
// corner sweep, a short run of maximum latencies, and random traffic under
// several idle and stall mixes. One phase holds m_tready low long enough to
// fill the input queue. Another waits for every pending result before it
// sends again.
// ----------------------------------------------------------------------------
module tb_latency_histogram_percentile
    import lhp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int FINE_SPAN   = FINE_BIN_COUNT_DEF * FINE_BIN_WIDTH_DEF;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_ADDS    = 40;
    localparam int PHASE_ITEMS = 500;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int unsigned s_idle_pct = 0;
    int unsigned m_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned backpressure_cycles = 0;

    class histogram_scoreboard;
        logic [LAT_W-1:0] fine_cnt [FINE_BIN_COUNT_DEF];
        logic [LAT_W-1:0] coarse_cnt [COARSE_COUNT];
        logic [LAT_W-1:0] samples;
        logic [LAT_W-1:0] min_lat;
        logic [LAT_W-1:0] max_lat;
        logic [SUM_W-1:0] lat_sum;
        result_t          expected_q [$];
        int unsigned      mismatches;
        int unsigned      results_seen;
        int unsigned      adds_seen;
        int unsigned      queries_seen;
        int unsigned      clears_seen;
        int unsigned      ignored_seen;
        bit               sum_saturated;

        function new();
            clear_stats();
        endfunction

        function void clear_stats();
            foreach (fine_cnt[i]) fine_cnt[i] = '0;
            foreach (coarse_cnt[i]) coarse_cnt[i] = '0;
            samples = '0;
            min_lat = ALL32;
            max_lat = '0;
            lat_sum = '0;
        endfunction

        function logic [LAT_W-1:0] sat_inc(input logic [LAT_W-1:0] v);
            return (v == ALL32) ? v : v + 1'b1;
        endfunction

        function void add_latency(input logic [LAT_W-1:0] us);
            logic [SUM_W:0] wide_sum;
            int             bin;
            samples = sat_inc(samples);
            wide_sum = {1'b0, lat_sum} + (SUM_W+1)'(us);
            if (wide_sum > {1'b0, SUM_MAX}) begin
                wide_sum = {1'b0, SUM_MAX};
                sum_saturated = 1'b1;
            end
            lat_sum = wide_sum[SUM_W-1:0];
            if (us < min_lat) min_lat = us;
            if (us > max_lat) max_lat = us;
            if (us < LAT_W'(FINE_SPAN)) begin
                bin = int'(us / LAT_W'(FINE_BIN_WIDTH_DEF));
                fine_cnt[bin] = sat_inc(fine_cnt[bin]);
            end else begin
                bin = EDGE_COUNT;
                for (int k = 0; k < EDGE_COUNT; k++) begin
                    if (bin == EDGE_COUNT && us < EDGE_US[k]) bin = k;
                end
                coarse_cnt[bin] = sat_inc(coarse_cnt[bin]);
            end
        endfunction

        // overflow bin is never walked; it is reached only through max_lat
        function logic [LAT_W-1:0] percentile_edge(input logic [PM_W-1:0] pm);
            logic [63:0] target;
            logic [63:0] acc;
            target = (64'(samples) * 64'(pm)) / 64'(PM_DIV);
            acc = '0;
            for (int i = 0; i < FINE_BIN_COUNT_DEF; i++) begin
                acc += 64'(fine_cnt[i]);
                if (acc >= target) return LAT_W'((i + 1) * FINE_BIN_WIDTH_DEF);
            end
            for (int i = 0; i < EDGE_COUNT; i++) begin
                acc += 64'(coarse_cnt[i]);
                if (acc >= target) return EDGE_US[i];
            end
            return max_lat;
        endfunction

        function void note_input(input logic [KIND_W-1:0] kind, input logic [LAT_W-1:0] lat,
                                 input logic [PM_W-1:0] pm);
            result_t stats;
            case (kind)
                KIND_ADD: begin
                    adds_seen++;
                    add_latency(lat);
                end
                KIND_QUERY: begin
                    queries_seen++;
                    stats.percentile_us = percentile_edge(pm);
                    stats.sample_total  = samples;
                    stats.min_us        = min_lat;
                    stats.max_us        = max_lat;
                    stats.sum_us        = lat_sum;
                    expected_q.push_back(stats);
                end
                KIND_CLEAR: begin
                    clears_seen++;
                    clear_stats();
                end
                default: ignored_seen++;
            endcase
        endfunction

        task report(input string what, input logic [SUM_W-1:0] got,
                    input logic [SUM_W-1:0] want);
            mismatches++;
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        endtask

        task check_result(input logic [M_TDATA_W-1:0] word);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected result, percentile_us", word[31:0], '0);
                return;
            end
            want = expected_q.pop_front();
            if (word[31:0] !== want.percentile_us)
                report("percentile_us", word[31:0], want.percentile_us);
            if (word[63:32] !== want.sample_total)
                report("sample_total", word[63:32], want.sample_total);
            if (word[95:64] !== want.min_us)
                report("min_us", word[95:64], want.min_us);
            if (word[127:96] !== want.max_us)
                report("max_us", word[127:96], want.max_us);
            if (word[175:128] !== want.sum_us)
                report("sum_us", word[175:128], want.sum_us);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    histogram_scoreboard sb;

    latency_histogram_percentile dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: check accepted words, then choose next m_tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
        if (aresetn && s_tvalid && !s_tready) begin
            backpressure_cycles++;
        end
        if (hold_req != holds_served) begin
            holds_served = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [LAT_W-1:0] lat,
                             input logic [PM_W-1:0] pm);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pm, lat};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(kind, lat, pm);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [LAT_W-1:0] pick_latency();
        logic [LAT_W-1:0] boundary;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return LAT_W'($urandom_range(FINE_SPAN - 1));
            5, 6, 7: return LAT_W'($urandom_range(600000, 2000));
            8: return $urandom();
            default: begin
                if ($urandom_range(1) == 1)
                    boundary = EDGE_US[$urandom_range(EDGE_COUNT - 1)];
                else
                    boundary = LAT_W'(FINE_BIN_WIDTH_DEF * $urandom_range(FINE_BIN_COUNT_DEF, 1));
                return boundary - 1 + LAT_W'($urandom_range(1));
            end
        endcase
    endfunction

    function automatic logic [PM_W-1:0] pick_permille();
        case ($urandom_range(9))
            0: return PM_W'($urandom_range(1023, 1001));
            1: return ($urandom_range(1) == 1) ? PM_DIV : '0;
            default: return PM_W'($urandom_range(1000));
        endcase
    endfunction

    task automatic send_random_item();
        int unsigned roll;
        roll = $urandom_range(999);
        if (roll < 700)
            send_word(KIND_ADD, pick_latency(), PM_W'($urandom()));
        else if (roll < 940)
            send_word(KIND_QUERY, $urandom(), pick_permille());
        else if (roll < 960)
            send_word(KIND_CLEAR, $urandom(), PM_W'($urandom()));
        else
            send_word(KIND_UNUSED, $urandom(), PM_W'($urandom()));
    endtask

    task automatic run_phase(input int unsigned s_pct, input int unsigned m_pct,
                             input bit with_hold, input bit with_pause);
        s_idle_pct  = s_pct;
        m_stall_pct = m_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (with_hold && n == PHASE_ITEMS / 2) begin
                hold_req <= hold_req + 1;
            end
            if (with_pause && n == PHASE_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_drained();
            end
            send_random_item();
        end
    endtask

    initial begin
        #(50_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners: empty stats, bin edges, overflow, pm above 1000
        send_word(KIND_QUERY, '0, 10'd500);
        send_word(KIND_QUERY, '0, 10'd1023);
        send_word(KIND_ADD, 32'd0, '0);
        send_word(KIND_ADD, 32'd9, '0);
        send_word(KIND_ADD, 32'd10, '0);
        send_word(KIND_ADD, 32'd1999, '0);
        send_word(KIND_ADD, 32'd2000, '0);
        send_word(KIND_ADD, 32'd4999, '0);
        send_word(KIND_ADD, 32'd499999, '0);
        send_word(KIND_ADD, 32'd500000, '0);
        send_word(KIND_ADD, ALL32, '0);
        send_word(KIND_QUERY, ALL32, '0);
        send_word(KIND_QUERY, '0, 10'd999);
        send_word(KIND_QUERY, '0, 10'd1000);
        send_word(KIND_QUERY, '0, 10'd1001);
        send_word(KIND_UNUSED, ALL32, '1);
        send_word(KIND_QUERY, '0, 10'd300);
        send_word(KIND_CLEAR, ALL32, '1);
        send_word(KIND_QUERY, '0, 10'd1000);
        send_word(KIND_ADD, 32'h5555_5555, 10'h2AA);
        send_word(KIND_QUERY, 32'hAAAA_AAAA, 10'h155);

        // run of maximum latencies
        send_word(KIND_CLEAR, '0, '0);
        for (int n = 0; n < MAX_ADDS; n++) begin
            send_word(KIND_ADD, ALL32, PM_W'($urandom()));
            if (n == MAX_ADDS - 6) send_word(KIND_QUERY, '0, 10'd1000);
        end
        send_word(KIND_QUERY, '0, '0);
        send_word(KIND_QUERY, '0, 10'd1000);
        send_word(KIND_CLEAR, '0, '0);

        run_phase(0, 0, 1'b1, 1'b0);
        run_phase(86, 0, 1'b0, 1'b1);
        run_phase(0, 86, 1'b0, 1'b0);
        run_phase(13, 13, 1'b0, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        repeat (600) @(posedge aclk);

        $display("summary: %0d adds, %0d queries, %0d clears, %0d unused-kind words, %0d results",
                 sb.adds_seen, sb.queries_seen, sb.clears_seen, sb.ignored_seen,
                 sb.results_seen);
        $display("summary: input back-pressured %0d cycles, sum saturation %0s",
                 backpressure_cycles, sb.sum_saturated ? "reached" : "not reached");
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
